FILE: hdl/standby_rail_power_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Standby rail power sequencer assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STANDBY_RAIL_POWER_SEQUENCER_DEFINES_SVH
`define STANDBY_RAIL_POWER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/srps_pkg.sv
// ----------------------------------------------------------------------------
// Standby rail power sequencer package
// Widths, reset values, phase codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package srps_pkg;

    localparam int LONG_W  = 11;
    localparam int SHORT_W = 10;
    localparam int DEB_W   = 6;
    localparam int CFG_IDX_W = 3;

    // Reset values of the configuration registers
    localparam logic [LONG_W-1:0]  POWER_UP_DELAY_RST    = 11'd300;
    localparam logic [LONG_W-1:0]  OCP_RETRY_DELAY_RST   = 11'd1100;
    localparam logic [SHORT_W-1:0] STATUS_OK_DELAY_RST   = 10'd1000;
    localparam logic [SHORT_W-1:0] MONITOR_DELAY_RST     = 10'd500;
    localparam logic [SHORT_W-1:0] FAULT_BLANK_DELAY_RST = 10'd1000;
    localparam logic [DEB_W-1:0]   VIN_DEBOUNCE_RST      = 6'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCP_RETRY_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OK_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_BLANK_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIN_DEBOUNCE      = 3'd5;

    // Sequencer phase codes
    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_ARMED = 2'd1;
    localparam logic [1:0] PH_CHECK = 2'd2;

    typedef struct packed {
        logic [LONG_W-1:0]  power_up_delay;
        logic [LONG_W-1:0]  ocp_retry_delay;
        logic [SHORT_W-1:0] status_ok_delay;
        logic [SHORT_W-1:0] monitor_delay;
        logic [SHORT_W-1:0] fault_blank_delay;
        logic [DEB_W-1:0]   vin_debounce;
    } srps_cfg_t;

    typedef struct packed {
        logic pson_active;
        logic rail_latched_off;
        logic aux_mode;
        logic relay_on;
        logic vin_ok;
        logic rail_overcurrent;
        logic main_fault;
    } srps_tick_t;

    typedef struct packed {
        logic       rail_enable;
        logic       rail_on_status;
        logic       monitor_enable;
        logic       clear_faults;
        logic [1:0] phase;
    } srps_result_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic [LONG_W-1:0]  turn_on_count;
        logic               clear_pending;
        logic [SHORT_W-1:0] ok_count;
        logic [SHORT_W-1:0] monitor_count;
        logic [DEB_W-1:0]   vin_bad_count;
        logic [SHORT_W-1:0] blank_count;
        logic               held_enable;
        logic               held_status;
        logic               held_monitor;
    } srps_state_t;

endpackage

FILE: hdl/srps_tick_if.sv
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel carrying one 1 ms tick of status flags.
// ----------------------------------------------------------------------------
interface srps_tick_if;
    logic valid;
    logic ready;
    logic pson_active;
    logic rail_latched_off;
    logic aux_mode;
    logic relay_on;
    logic vin_ok;
    logic rail_overcurrent;
    logic main_fault;

    modport source (
        output valid, pson_active, rail_latched_off, aux_mode, relay_on, vin_ok,
               rail_overcurrent, main_fault,
        input  ready
    );
    modport sink (
        input  valid, pson_active, rail_latched_off, aux_mode, relay_on, vin_ok,
               rail_overcurrent, main_fault,
        output ready
    );
endinterface

FILE: hdl/srps_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the sequencer outputs after each tick.
// ----------------------------------------------------------------------------
interface srps_result_if;
    logic       valid;
    logic       ready;
    logic       rail_enable;
    logic       rail_on_status;
    logic       monitor_enable;
    logic       clear_faults;
    logic [1:0] phase;

    modport source (
        output valid, rail_enable, rail_on_status, monitor_enable, clear_faults, phase,
        input  ready
    );
    modport sink (
        input  valid, rail_enable, rail_on_status, monitor_enable, clear_faults, phase,
        output ready
    );
endinterface

FILE: hdl/srps_step.sv
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next state and result of the sequencer for one tick.
// ----------------------------------------------------------------------------
module srps_step (
    input  srps_pkg::srps_state_t  st,
    input  srps_pkg::srps_cfg_t    cfg,
    input  srps_pkg::srps_tick_t   tick_data,
    output srps_pkg::srps_state_t  nxt,
    output srps_pkg::srps_result_t res
);
    import srps_pkg::*;

    logic [LONG_W-1:0]  turn_on_dec;
    logic [SHORT_W-1:0] blank_dec;
    logic               late_fault;
    logic               clr;

    // Saturating countdowns, tested after the decrement
    assign turn_on_dec = (st.turn_on_count != '0) ? st.turn_on_count - 1'b1 : '0;
    assign blank_dec   = (st.blank_count != '0) ? st.blank_count - 1'b1 : '0;
    assign late_fault  = (blank_dec == '0) && tick_data.main_fault;

    // Advance the sequencer
    always_comb
    begin
        nxt = st;
        clr = 1'b0;
        case (st.phase)
            PH_INIT:
            begin
                nxt.held_enable   = 1'b0;
                nxt.held_status   = 1'b0;
                nxt.held_monitor  = 1'b0;
                nxt.monitor_count = '0;
                if (tick_data.pson_active)
                    nxt.clear_pending = 1'b1;
                nxt.turn_on_count = turn_on_dec;
                if (turn_on_dec == '0 && !tick_data.rail_latched_off && !tick_data.aux_mode)
                    nxt.phase = PH_ARMED;
            end
            PH_ARMED:
            begin
                if (tick_data.relay_on && tick_data.vin_ok)
                begin
                    if (st.clear_pending)
                    begin
                        clr = 1'b1;
                        nxt.clear_pending = 1'b0;
                    end
                    nxt.phase         = PH_CHECK;
                    nxt.held_enable   = 1'b1;
                    nxt.ok_count      = '0;
                    nxt.vin_bad_count = '0;
                    nxt.blank_count   = cfg.fault_blank_delay;
                end
            end
            PH_CHECK:
            begin
                if (st.ok_count > cfg.status_ok_delay)
                    nxt.held_status = 1'b1;
                else
                    nxt.ok_count = st.ok_count + 1'b1;
                if (st.monitor_count < cfg.monitor_delay)
                    nxt.monitor_count = st.monitor_count + 1'b1;
                else
                    nxt.held_monitor = 1'b1;
                nxt.blank_count = blank_dec;
                // Debounced input loss or late fault wins over the immediate restarts
                if (!tick_data.vin_ok || late_fault)
                begin
                    if (st.vin_bad_count < cfg.vin_debounce)
                        nxt.vin_bad_count = st.vin_bad_count + 1'b1;
                    else
                    begin
                        nxt.phase         = PH_INIT;
                        nxt.turn_on_count = cfg.power_up_delay;
                    end
                end
                else if (tick_data.rail_overcurrent)
                begin
                    nxt.phase         = PH_INIT;
                    nxt.turn_on_count = cfg.ocp_retry_delay;
                end
                else if (tick_data.rail_latched_off || tick_data.aux_mode)
                begin
                    nxt.phase         = PH_INIT;
                    nxt.turn_on_count = cfg.power_up_delay;
                end
            end
            default:
            begin
                // Unused phase code: restart from init
                nxt.phase         = PH_INIT;
                nxt.turn_on_count = cfg.power_up_delay;
            end
        endcase
    end

    // Pack the result
    always_comb
    begin
        res.rail_enable    = nxt.held_enable;
        res.rail_on_status = nxt.held_status;
        res.monitor_enable = nxt.held_monitor;
        res.clear_faults   = clr;
        res.phase          = nxt.phase;
    end

endmodule

FILE: hdl/standby_rail_power_sequencer.sv
// ----------------------------------------------------------------------------
// Standby rail power sequencer
// Result valid rises in the cycle after a tick is accepted, via the result register.
// One tick per cycle unless the result stalls; state advances on each accepted tick.
// Reset: state and the six delay registers return to defaults; result data does not.
// ----------------------------------------------------------------------------
module standby_rail_power_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srps_pkg::LONG_W-1:0]       cfg_data,
    srps_tick_if.sink                         tick,
    srps_result_if.source                     result
);
    import srps_pkg::*;

    srps_cfg_t    cfg_reg;
    srps_state_t  state_reg;
    srps_state_t  state_next;
    srps_tick_t   tick_data;
    srps_result_t res_next;
    srps_result_t res_reg;
    logic         res_valid_reg;
    logic         tick_accept;

    // Take a new request whenever the result register is free or draining
    assign tick.ready  = !res_valid_reg || result.ready;
    assign tick_accept = tick.valid && tick.ready;

    assign tick_data.pson_active      = tick.pson_active;
    assign tick_data.rail_latched_off = tick.rail_latched_off;
    assign tick_data.aux_mode         = tick.aux_mode;
    assign tick_data.relay_on         = tick.relay_on;
    assign tick_data.vin_ok           = tick.vin_ok;
    assign tick_data.rail_overcurrent = tick.rail_overcurrent;
    assign tick_data.main_fault       = tick.main_fault;

    srps_step u_step (
        .st        (state_reg),
        .cfg       (cfg_reg),
        .tick_data (tick_data),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_delay    <= POWER_UP_DELAY_RST;
            cfg_reg.ocp_retry_delay   <= OCP_RETRY_DELAY_RST;
            cfg_reg.status_ok_delay   <= STATUS_OK_DELAY_RST;
            cfg_reg.monitor_delay     <= MONITOR_DELAY_RST;
            cfg_reg.fault_blank_delay <= FAULT_BLANK_DELAY_RST;
            cfg_reg.vin_debounce      <= VIN_DEBOUNCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER_UP_DELAY:    cfg_reg.power_up_delay    <= cfg_data;
                CFG_OCP_RETRY_DELAY:   cfg_reg.ocp_retry_delay   <= cfg_data;
                CFG_STATUS_OK_DELAY:   cfg_reg.status_ok_delay   <= cfg_data[SHORT_W-1:0];
                CFG_MONITOR_DELAY:     cfg_reg.monitor_delay     <= cfg_data[SHORT_W-1:0];
                CFG_FAULT_BLANK_DELAY: cfg_reg.fault_blank_delay <= cfg_data[SHORT_W-1:0];
                CFG_VIN_DEBOUNCE:      cfg_reg.vin_debounce      <= cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold sequencer state; advance it on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_INIT;
            state_reg.turn_on_count <= POWER_UP_DELAY_RST;
            state_reg.clear_pending <= 1'b0;
            state_reg.ok_count      <= '0;
            state_reg.monitor_count <= '0;
            state_reg.vin_bad_count <= '0;
            state_reg.blank_count   <= '0;
            state_reg.held_enable   <= 1'b0;
            state_reg.held_status   <= 1'b0;
            state_reg.held_monitor  <= 1'b0;
        end
        else if (tick_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (tick_accept)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload, loaded with each accepted tick
    always_ff @(posedge clk)
    begin
        if (tick_accept)
            res_reg <= res_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.rail_enable    = res_reg.rail_enable;
    assign result.rail_on_status = res_reg.rail_on_status;
    assign result.monitor_enable = res_reg.monitor_enable;
    assign result.clear_faults   = res_reg.clear_faults;
    assign result.phase          = res_reg.phase;

endmodule

FILE: hdl/srps_checker.sv
// ----------------------------------------------------------------------------
// Sequencer port checker
// Port-level properties of the standby rail power sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "standby_rail_power_sequencer_defines.svh"

module srps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       rail_enable,
    input logic       rail_on_status,
    input logic       monitor_enable,
    input logic       clear_faults,
    input logic [1:0] phase
);
    import srps_pkg::*;

    // A stalled result holds
    `SRPS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({rail_enable, rail_on_status, monitor_enable, clear_faults, phase}), "stalled result changed")

    // Every accepted request produces a result in the next cycle
    `SRPS_ASSERT_NEXT(a_tick_to_res, clk, rst_n, tick_valid && tick_ready, res_valid, "accepted tick gave no result")

    // The fault-clear pulse comes only with the rail enabled in checking
    `SRPS_ASSERT_NOW(a_clear_in_check, clk, rst_n, res_valid && clear_faults, rail_enable && phase == PH_CHECK, "clear pulse outside rail turn-on")

    // Status and monitor never come on without the rail enabled
    `SRPS_ASSERT_NOW(a_status_needs_enable, clk, rst_n, res_valid && (rail_on_status || monitor_enable), rail_enable, "status or monitor without rail enable")

    // The unused phase code never shows
    `SRPS_ASSERT_NOW(a_phase_legal, clk, rst_n, res_valid, phase == PH_INIT || phase == PH_ARMED || phase == PH_CHECK, "illegal phase code")

endmodule

bind standby_rail_power_sequencer srps_checker u_srps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_valid     (tick.valid),
    .tick_ready     (tick.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .rail_enable    (result.rail_enable),
    .rail_on_status (result.rail_on_status),
    .monitor_enable (result.monitor_enable),
    .clear_faults   (result.clear_faults),
    .phase          (result.phase)
);
